// ===== sv/set_assoc_cache_lru_classifier_macros.svh =====
// Assertion macros shared by the cache classifier modules.
`ifndef SET_ASSOC_CACHE_LRU_CLASSIFIER_MACROS_SVH
`define SET_ASSOC_CACHE_LRU_CLASSIFIER_MACROS_SVH
`ifndef SYNTHESIS
`define SACL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SACL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SACL_ASSERT_SAME(lbl, ante, cons, msg)
`define SACL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/sacl_pkg.sv =====
// Shared constants, types and command structs of the cache classifier.
package sacl_pkg;

  localparam int MAX_SET_BITS = 6;
  localparam int MAX_WAYS     = 8;
  localparam int ADDR_WIDTH   = 32;

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_W    = RANK_W;

  localparam int OP_W       = 2;
  localparam int SETB_W     = 3;
  localparam int OFFB_W     = 5;
  localparam int WAYS_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int CNT_W      = 32;
  localparam int SH_W       = $clog2(MAX_SET_BITS + (1 << OFFB_W) + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS        = 2'd2;

  // Bit 1 of the operation marks a modify: two accesses.
  localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;

  typedef struct packed {
    logic [MAX_WAYS-1:0]                 valid;
    logic [MAX_WAYS-1:0][RANK_W-1:0]     rank;
    logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag;
  } row_t;

  typedef struct packed {
    logic start;
    logic reread;
    logic commit;
    logic last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic slot_free;
  } dp_status_t;

endpackage

// ===== sv/sacl_ctrl.sv =====
// Sequencer of the cache classifier: accept, look up, commit, second pass.
`include "set_assoc_cache_lru_classifier_macros.svh"
module sacl_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [sacl_pkg::OP_W-1:0] in_operation,
  input  sacl_pkg::dp_status_t    status,
  output sacl_pkg::ctrl_cmd_t     cmd
);
  import sacl_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_LOOK   = 3'b010,
    ST_REREAD = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   more_r, more_nxt;

  always_comb begin
    state_nxt  = state_r;
    more_nxt   = more_r;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          more_nxt  = (in_operation & OP_MODIFY) != '0;
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        // hold until the result register can take the new result
        if (status.slot_free) begin
          cmd.commit = 1'b1;
          cmd.last   = !more_r;
          more_nxt   = 1'b0;
          state_nxt  = more_r ? ST_REREAD : ST_IDLE;
        end
      end
      ST_REREAD: begin
        cmd.reread = 1'b1;
        state_nxt  = ST_LOOK;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      more_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      more_r  <= more_nxt;
    end
  end

  `SACL_ASSERT_NEXT(a_second_pass, cmd.commit && !cmd.last, cmd.reread,
                    "modify lost its second access")
  `SACL_ASSERT_NEXT(a_one_request, cmd.start, !in_ready && !cmd.start,
                    "request taken while busy")
  `SACL_ASSERT_SAME(a_commit_free, cmd.commit, status.slot_free,
                    "result committed onto a full register")

endmodule

// ===== sv/sacl_datapath.sv =====
// Tag store, LRU lookup and update, totals and result register.
`include "set_assoc_cache_lru_classifier_macros.svh"
module sacl_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sacl_pkg::ctrl_cmd_t           cmd,
  output sacl_pkg::dp_status_t          status,
  input  logic [sacl_pkg::ADDR_WIDTH-1:0] in_address,
  input  logic                          cfg_we,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sacl_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_hit,
  output logic                          out_eviction,
  output logic                          out_last,
  output logic [sacl_pkg::CNT_W-1:0]    out_hit_total,
  output logic [sacl_pkg::CNT_W-1:0]    out_miss_total,
  output logic [sacl_pkg::CNT_W-1:0]    out_eviction_total
);
  import sacl_pkg::*;

  logic [SETB_W-1:0] set_bits_r;
  logic [OFFB_W-1:0] off_bits_r;
  logic [WAYS_W-1:0] ways_r;
  logic [SETB_W-1:0] s_eff;
  logic [WAYS_W-1:0] ways_eff;

  logic [ADDR_WIDTH-1:0]   addr_r, addr_src, addr_shifted;
  logic [SET_W-1:0]        rd_set, set_r;
  logic [SH_W-1:0]         sh;
  logic [2*ADDR_WIDTH-1:0] tag_wide;
  logic [ADDR_WIDTH-1:0]   tag_cur;
  logic                    rd_en;

  row_t              mem [NUM_SETS];
  row_t              rd_row_r;
  logic              rd_live_r;
  logic [NUM_SETS-1:0] row_live_r;

  row_t              cur, new_row;
  logic [MAX_WAYS-1:0] used, match;
  logic              hit_found, free_found, evict;
  logic [WAY_W-1:0]  hit_way, free_way, victim, sel_way;
  logic [RANK_W:0]   old_rank;

  logic [CNT_W-1:0]  hit_cnt_r, miss_cnt_r, evict_cnt_r;
  logic              out_valid_r, out_hit_r, out_evict_r, out_last_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r <= '0;
      off_bits_r <= '0;
      ways_r     <= WAYS_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SET_BITS:    set_bits_r <= cfg_wdata[SETB_W-1:0];
        CFG_OFFSET_BITS: off_bits_r <= cfg_wdata[OFFB_W-1:0];
        CFG_WAYS:        ways_r     <= cfg_wdata[WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp out-of-range settings
  always_comb begin
    s_eff = (int'(set_bits_r) > MAX_SET_BITS) ? SETB_W'(MAX_SET_BITS) : set_bits_r;
    if (ways_r == '0) begin
      ways_eff = WAYS_W'(1);
    end else if (int'(ways_r) > MAX_WAYS) begin
      ways_eff = WAYS_W'(MAX_WAYS);
    end else begin
      ways_eff = ways_r;
    end
  end

  // set index and tag
  assign rd_en        = cmd.start || cmd.reread;
  assign addr_src     = cmd.start ? in_address : addr_r;
  assign addr_shifted = addr_src >> off_bits_r;
  assign rd_set       = addr_shifted[SET_W-1:0] & ~({SET_W{1'b1}} << s_eff);
  assign sh           = SH_W'(s_eff) + SH_W'(off_bits_r);
  assign tag_wide     = {{ADDR_WIDTH{1'b0}}, addr_r} >> sh;
  assign tag_cur      = tag_wide[ADDR_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (cmd.start) addr_r <= in_address;
    if (rd_en)     set_r  <= rd_set;
  end

  // tag store: one row per set, read-modify-write of the whole row
  always_ff @(posedge clk) begin
    if (rd_en)      rd_row_r   <= mem[rd_set];
    if (cmd.commit) mem[set_r] <= new_row;
  end

  // a row never written reads as empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_live_r <= '0;
      rd_live_r  <= 1'b0;
    end else begin
      if (rd_en)      rd_live_r         <= row_live_r[rd_set];
      if (cmd.commit) row_live_r[set_r] <= 1'b1;
    end
  end

  // lookup, victim choice and recency update
  always_comb begin
    cur = rd_row_r;
    if (!rd_live_r) begin
      cur.valid = '0;
      cur.rank  = '0;
    end
    for (int j = 0; j < MAX_WAYS; j++) begin
      used[j]  = j < int'(ways_eff);
      match[j] = used[j] && cur.valid[j] && (cur.tag[j] == tag_cur);
    end
    hit_found  = 1'b0;
    hit_way    = '0;
    free_found = 1'b0;
    free_way   = '0;
    for (int j = MAX_WAYS - 1; j >= 0; j--) begin
      if (match[j]) begin
        hit_found = 1'b1;
        hit_way   = WAY_W'(j);
      end
      if (used[j] && !cur.valid[j]) begin
        free_found = 1'b1;
        free_way   = WAY_W'(j);
      end
    end
    // oldest used way, lowest on a tie
    victim = '0;
    for (int j = 1; j < MAX_WAYS; j++) begin
      if (used[j] && (cur.rank[j] > cur.rank[victim])) victim = WAY_W'(j);
    end
    evict = !hit_found && !free_found;
    if (hit_found) begin
      sel_way  = hit_way;
      old_rank = {1'b0, cur.rank[hit_way]};
    end else begin
      sel_way  = free_found ? free_way : victim;
      old_rank = (RANK_W+1)'(MAX_WAYS);
    end
    new_row = cur;
    for (int j = 0; j < MAX_WAYS; j++) begin
      if (used[j] && (WAY_W'(j) != sel_way) && cur.valid[j] &&
          ({1'b0, cur.rank[j]} < old_rank) && (int'(cur.rank[j]) < MAX_WAYS - 1)) begin
        new_row.rank[j] = cur.rank[j] + 1'b1;
      end
    end
    new_row.rank[sel_way] = '0;
    if (!hit_found) begin
      new_row.valid[sel_way] = 1'b1;
      new_row.tag[sel_way]   = tag_cur;
    end
  end

  // totals and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      hit_cnt_r   <= hit_cnt_r + CNT_W'(hit_found);
      miss_cnt_r  <= miss_cnt_r + CNT_W'(!hit_found);
      evict_cnt_r <= evict_cnt_r + CNT_W'(evict);
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit_r   <= hit_found;
      out_evict_r <= evict;
      out_last_r  <= cmd.last;
    end
  end

  assign status.slot_free   = !out_valid_r || out_ready;
  assign out_valid          = out_valid_r;
  assign out_hit            = out_hit_r;
  assign out_eviction       = out_evict_r;
  assign out_last           = out_last_r;
  assign out_hit_total      = hit_cnt_r;
  assign out_miss_total     = miss_cnt_r;
  assign out_eviction_total = evict_cnt_r;

  `SACL_ASSERT_NEXT(a_total_step, cmd.commit,
                    CNT_W'(hit_cnt_r + miss_cnt_r) ==
                    CNT_W'($past(hit_cnt_r + miss_cnt_r) + 1'b1),
                    "access totals did not advance by one")
  `SACL_ASSERT_SAME(a_flags_apart, out_valid_r, !(out_hit_r && out_evict_r),
                    "hit and eviction both set")
  `SACL_ASSERT_NEXT(a_result_held, out_valid_r && !out_ready,
                    out_valid_r && $stable(out_hit_r) && $stable(hit_cnt_r),
                    "waiting result changed")

endmodule

// ===== sv/set_assoc_cache_lru_classifier.sv =====
// Set-associative cache classifier with true LRU: top level.
// Each access: a registered row read, then a lookup committed to the result register;
// a modify's second access rereads the row. A new request is taken only once the
// last result of the one before is committed; each access is held while a full result
// register is not taken. Reset (synchronous, rst_n low): clears totals, set and offset
// bits and 64 row-valid flags, sets one way; no clearing pass over the tag store.
module set_assoc_cache_lru_classifier (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [sacl_pkg::OP_W-1:0]       in_operation,
  input  logic [sacl_pkg::ADDR_WIDTH-1:0] in_address,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_hit,
  output logic                            out_eviction,
  output logic                            out_last,
  output logic [sacl_pkg::CNT_W-1:0]      out_hit_total,
  output logic [sacl_pkg::CNT_W-1:0]      out_miss_total,
  output logic [sacl_pkg::CNT_W-1:0]      out_eviction_total,
  input  logic                            cfg_we,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sacl_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import sacl_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  sacl_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .status       (status),
    .cmd          (cmd)
  );

  sacl_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_address         (in_address),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_hit            (out_hit),
    .out_eviction       (out_eviction),
    .out_last           (out_last),
    .out_hit_total      (out_hit_total),
    .out_miss_total     (out_miss_total),
    .out_eviction_total (out_eviction_total)
  );

endmodule

// ===== sim/tb_top.sv =====
// Self-checking bench for the LRU cache classifier: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_top;
  import sacl_pkg::*;

  localparam logic [OP_W-1:0] OP_LOAD       = 2'd0;
  localparam logic [OP_W-1:0] OP_STORE      = 2'd1;
  localparam logic [OP_W-1:0] OP_MODIFY_ALT = 2'd3;   // bit 1 set, so a modify
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // no register behind it

  localparam int NUM_LINES    = NUM_SETS * MAX_WAYS;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_CYCLES = 4;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 175;
  localparam int SCRIPT_LEN   = 32;

  typedef struct packed {
    logic              hit;
    logic              eviction;
    logic              last;
    logic [CNT_W-1:0]  hit_total;
    logic [CNT_W-1:0]  miss_total;
    logic [CNT_W-1:0]  eviction_total;
  } cache_result_t;

  typedef enum logic {ROW_ACCESS, ROW_CONFIG} row_kind_t;

  typedef struct packed {
    row_kind_t      kind;
    logic [1:0]     code;    // operation, or register index
    logic [31:0]    value;   // address, or register data
    logic           typed;
    cache_result_t  want;
  } script_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [OP_W-1:0]       in_operation = '0;
  logic [ADDR_WIDTH-1:0] in_address = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_hit;
  logic                  out_eviction;
  logic                  out_last;
  logic [CNT_W-1:0]      out_hit_total;
  logic [CNT_W-1:0]      out_miss_total;
  logic [CNT_W-1:0]      out_eviction_total;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Shadow cache state and settings
  bit              way_valid [NUM_LINES];
  bit [31:0]       way_tag   [NUM_LINES];
  bit [RANK_W-1:0] way_rank  [NUM_LINES];
  bit [CNT_W-1:0]  hit_count;
  bit [CNT_W-1:0]  miss_count;
  bit [CNT_W-1:0]  eviction_count;
  bit [SETB_W-1:0] model_set_bits = '0;
  bit [OFFB_W-1:0] model_offset_bits = '0;
  bit [WAYS_W-1:0] model_ways = 4'd1;

  cache_result_t pending_results [$];
  int unsigned   error_count = 0;
  int unsigned   cycle_count = 0;
  bit            steady = 1'b0;

  script_row_t script_rows [SCRIPT_LEN] = '{
    // one set, one way after reset: tag is the whole address
    '{ROW_ACCESS, OP_LOAD,  32'h0000_0000, 1'b1, '{1'b0, 1'b0, 1'b1, 32'd0, 32'd1, 32'd0}},
    '{ROW_ACCESS, OP_LOAD,  32'h0000_0000, 1'b1, '{1'b1, 1'b0, 1'b1, 32'd1, 32'd1, 32'd0}},
    '{ROW_ACCESS, OP_STORE, 32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b1, 1'b1, 32'd1, 32'd2, 32'd1}},
    '{ROW_ACCESS, OP_MODIFY,    32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_ACCESS, OP_MODIFY_ALT, 32'h0000_0000, 1'b0, '0},
    // oversized set field, widest offset, zero ways: tag shifted out entirely
    '{ROW_CONFIG, CFG_SET_BITS,    32'd7,  1'b0, '0},
    '{ROW_CONFIG, CFG_OFFSET_BITS, 32'd31, 1'b0, '0},
    '{ROW_CONFIG, CFG_WAYS,        32'd0,  1'b0, '0},
    '{ROW_ACCESS, OP_LOAD,  32'h8000_0000, 1'b0, '0},
    '{ROW_ACCESS, OP_STORE, 32'h7FFF_FFFF, 1'b0, '0},
    // four sets of 16-byte blocks, ways above the maximum: fill set 3 and evict
    '{ROW_CONFIG, CFG_SET_BITS,    32'd2,  1'b0, '0},
    '{ROW_CONFIG, CFG_OFFSET_BITS, 32'd4,  1'b0, '0},
    '{ROW_CONFIG, CFG_WAYS,        32'd15, 1'b0, '0},
    '{ROW_ACCESS, OP_LOAD,  32'h0000_0070, 1'b0, '0},
    '{ROW_ACCESS, OP_LOAD,  32'h0000_00B0, 1'b0, '0},
    '{ROW_ACCESS, OP_STORE, 32'h0000_00F0, 1'b0, '0},
    '{ROW_ACCESS, OP_LOAD,  32'h0000_0130, 1'b0, '0},
    '{ROW_ACCESS, OP_LOAD,  32'h0000_0170, 1'b0, '0},
    '{ROW_ACCESS, OP_STORE, 32'h0000_01B0, 1'b0, '0},
    '{ROW_ACCESS, OP_LOAD,  32'h0000_01F0, 1'b0, '0},
    '{ROW_ACCESS, OP_LOAD,  32'h0000_0230, 1'b0, '0},
    '{ROW_ACCESS, OP_LOAD,  32'h0000_0270, 1'b0, '0},
    '{ROW_ACCESS, OP_STORE, 32'h0000_00B0, 1'b0, '0},
    '{ROW_ACCESS, OP_MODIFY, 32'h0000_0270, 1'b0, '0},
    // shrink the ways: ranks left from eight ways decide the victim
    '{ROW_CONFIG, CFG_WAYS,        32'd3,  1'b0, '0},
    '{ROW_ACCESS, OP_LOAD,  32'h0000_0CB0, 1'b0, '0},
    '{ROW_CONFIG, CFG_SET_BITS,    32'd6,  1'b0, '0},
    '{ROW_CONFIG, CFG_OFFSET_BITS, 32'd0,  1'b0, '0},
    '{ROW_CONFIG, CFG_WAYS,        32'd8,  1'b0, '0},
    '{ROW_CONFIG, CFG_SPARE,       32'd31, 1'b0, '0},
    '{ROW_ACCESS, OP_LOAD,  32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_ACCESS, OP_MODIFY, 32'h0000_0000, 1'b0, '0}
  };

  set_assoc_cache_lru_classifier dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_address         (in_address),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_hit            (out_hit),
    .out_eviction       (out_eviction),
    .out_last           (out_last),
    .out_hit_total      (out_hit_total),
    .out_miss_total     (out_miss_total),
    .out_eviction_total (out_eviction_total),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Make way w the most recent; used valid ways younger than old_rank age by one.
  function automatic void promote(int unsigned base, int unsigned ways, int unsigned w,
                                  int unsigned old_rank);
    int unsigned j;
    for (j = 0; j < ways; j++) begin
      if (j != w && way_valid[base + j] && way_rank[base + j] < old_rank &&
          way_rank[base + j] < MAX_WAYS - 1)
        way_rank[base + j] = way_rank[base + j] + 1'b1;
    end
    way_rank[base + w] = '0;
  endfunction

  function automatic cache_result_t lookup_access(logic [31:0] addr);
    int unsigned   set_bits, ways, set_no, shift, base, way, victim;
    logic [63:0]   wide;
    logic [31:0]   tag;
    bit            found;
    cache_result_t res;
    set_bits = (model_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : model_set_bits;
    ways = (model_ways == 0) ? 1 : ((model_ways > MAX_WAYS) ? MAX_WAYS : model_ways);
    wide = {32'd0, addr};
    set_no = int'((wide >> model_offset_bits) & ((64'd1 << set_bits) - 64'd1));
    shift = set_bits + model_offset_bits;
    tag = 32'(wide >> shift);
    base = set_no * MAX_WAYS;
    res = '0;
    found = 1'b0;
    for (way = 0; way < ways && !found; way++) begin
      if (way_valid[base + way] && way_tag[base + way] == tag) begin
        found = 1'b1;
        promote(base, ways, way, way_rank[base + way]);
      end
    end
    if (found) begin
      res.hit = 1'b1;
      hit_count++;
    end else begin
      miss_count++;
      way = 0;
      while (way < ways && way_valid[base + way])
        way++;
      if (way < ways) begin
        way_valid[base + way] = 1'b1;
        way_tag[base + way] = tag;
        promote(base, ways, way, MAX_WAYS);
      end else begin
        // oldest used way, lowest number on a tie
        victim = 0;
        for (way = 1; way < ways; way++)
          if (way_rank[base + way] > way_rank[base + victim])
            victim = way;
        res.eviction = 1'b1;
        eviction_count++;
        way_tag[base + victim] = tag;
        promote(base, ways, victim, MAX_WAYS);
      end
    end
    res.hit_total = hit_count;
    res.miss_total = miss_count;
    res.eviction_total = eviction_count;
    return res;
  endfunction

  function automatic void classify_request(logic [OP_W-1:0] op, logic [31:0] addr);
    int            n, k;
    cache_result_t res;
    n = op[1] ? 2 : 1;
    for (k = 0; k < n; k++) begin
      res = lookup_access(addr);
      res.last = (k == n - 1);
      pending_results.push_back(res);
    end
  endfunction

  // Entered and left at a falling edge; valid stays high after acceptance.
  task automatic send_request(logic [OP_W-1:0] op, logic [31:0] addr, logic typed,
                              cache_result_t want);
    bit taken;
    if (!steady) begin
      while ($urandom_range(0, 99) < 7) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_operation <= op;
    in_address <= addr;
    in_valid <= 1'b1;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      if (in_ready) begin
        taken = 1'b1;
        classify_request(op, addr);
        if (typed)
          pending_results[pending_results.size() - 1] = want;
      end
      @(negedge clk);
    end
  endtask

  // Drop the request line and hold until every expected result has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_SET_BITS:    model_set_bits = data[SETB_W-1:0];
      CFG_OFFSET_BITS: model_offset_bits = data[OFFB_W-1:0];
      CFG_WAYS:        model_ways = data[WAYS_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 7);
  end

  always @(posedge clk) begin
    cache_result_t got, exp_res;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_hit, out_eviction, out_last, out_hit_total, out_miss_total,
              out_eviction_total};
      if (pending_results.size() == 0) begin
        if (error_count < 10)
          $display("[%0t] result with no request pending", $realtime);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (got !== exp_res) begin
          if (error_count < 10) begin
            $display("[%0t] mismatch: expected hit=%0b ev=%0b last=%0b h/m/e=%0d/%0d/%0d",
                     $realtime, exp_res.hit, exp_res.eviction, exp_res.last,
                     exp_res.hit_total, exp_res.miss_total, exp_res.eviction_total);
            $display("    got hit=%0b ev=%0b last=%0b h/m/e=%0d/%0d/%0d",
                     got.hit, got.eviction, got.last,
                     got.hit_total, got.miss_total, got.eviction_total);
          end
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int unsigned   row, phase, k, set_bits, ways, pick;
    logic [63:0]   addr_wide;
    logic [31:0]   tag;
    logic [OP_W-1:0] op;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (row = 0; row < SCRIPT_LEN; row++) begin
      if (script_rows[row].kind == ROW_CONFIG) begin
        wait_idle();
        write_register(script_rows[row].code, script_rows[row].value[CFG_DATA_W-1:0]);
      end else begin
        send_request(script_rows[row].code, script_rows[row].value, script_rows[row].typed,
                     script_rows[row].want);
      end
    end

    for (phase = 0; phase < RAND_PHASES; phase++) begin
      wait_idle();
      steady = (phase == 3);
      write_register(CFG_SET_BITS, CFG_DATA_W'($urandom_range(0, 7)));
      write_register(CFG_OFFSET_BITS, ($urandom_range(0, 3) == 0) ?
                     CFG_DATA_W'($urandom_range(0, 31)) : CFG_DATA_W'($urandom_range(0, 6)));
      write_register(CFG_WAYS, CFG_DATA_W'($urandom_range(0, 15)));
      set_bits = (model_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : model_set_bits;
      ways = (model_ways == 0) ? 1 : ((model_ways > MAX_WAYS) ? MAX_WAYS : model_ways);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        op = OP_W'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          addr_wide = {32'd0, $urandom()};
        end else begin
          // few tags over few sets so lines get reused and evicted
          tag = $urandom_range(0, ways + 2);
          if (pick < 25)
            tag = ~tag;
          addr_wide = ({32'd0, tag} << (set_bits + model_offset_bits)) |
                      ((64'($urandom_range(0, 3)) & ((64'd1 << set_bits) - 64'd1))
                       << model_offset_bits) |
                      (64'($urandom()) & ((64'd1 << model_offset_bits) - 64'd1));
        end
        send_request(op, addr_wide[31:0], 1'b0, '0);
      end
    end
    steady = 1'b0;

    wait_idle();
    repeat (10) @(posedge clk);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
